[sv/i3kf_pkg.sv]
// Package for the 3x3 kernel image filter: payload structs, register indexes,
// filter codes, kernel weights and arithmetic constants.
// No dependencies; the lane, merge stage, top level and testbench import it.
`default_nettype none

package i3kf_pkg;

  typedef logic [23:0] pixel_t;

  typedef struct packed {
    logic       command;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } pixel_in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       frame_last;
  } pixel_out_t;

  // Control carried with a request down the filter pipeline.
  typedef struct packed {
    logic emit;
    logic border;
    logic last;
  } stage_ctl_t;

  typedef enum logic [1:0] {
    CFG_FILTER_MODE  = 2'd0,
    CFG_IMAGE_WIDTH  = 2'd1,
    CFG_IMAGE_HEIGHT = 2'd2,
    CFG_COLOR_MODE   = 2'd3
  } cfg_index_e;

  localparam logic [2:0] FM_SMOOTH  = 3'd0;
  localparam logic [2:0] FM_BLUR    = 3'd1;
  localparam logic [2:0] FM_SHARPEN = 3'd2;
  localparam logic [2:0] FM_MEAN    = 3'd3;
  localparam logic [2:0] FM_EMBOSS  = 3'd4;
  localparam logic [2:0] FM_ZERO    = 3'd5;

  localparam logic        CMD_PIXEL = 1'b0;
  localparam logic        CMD_FLUSH = 1'b1;

  localparam logic [2:0]  FILTER_MODE_RST  = FM_SMOOTH;
  localparam logic [12:0] IMAGE_WIDTH_RST  = 13'd640;
  localparam logic [15:0] IMAGE_HEIGHT_RST = 16'd480;
  localparam logic        COLOR_MODE_RST   = 1'b0;

  // Weighted sums stay within -2040..4080.
  localparam int unsigned SUM_W = 13;

  // Reciprocals scaled by 2^16; exact truncating quotients for sums below 2^15.
  localparam int unsigned RECIP_SHIFT = 16;
  localparam int unsigned RECIP9      = 7282;
  localparam int unsigned RECIP3      = 21846;

  localparam int unsigned OQ_DEPTH = 8;
  localparam int unsigned OQ_PTR_W = $clog2(OQ_DEPTH);
  localparam int unsigned OQ_CNT_W = $clog2(OQ_DEPTH + 1);

  typedef logic signed [4:0] weight_t;

  localparam weight_t KERNELS [6][9] = '{
    '{5'sd1, 5'sd1, 5'sd1, 5'sd1, 5'sd1, 5'sd1, 5'sd1, 5'sd1, 5'sd1},
    '{5'sd1, 5'sd2, 5'sd1, 5'sd2, 5'sd4, 5'sd2, 5'sd1, 5'sd2, 5'sd1},
    '{5'sd0, -5'sd2, 5'sd0, -5'sd2, 5'sd11, -5'sd2, 5'sd0, -5'sd2, 5'sd0},
    '{-5'sd1, -5'sd1, -5'sd1, -5'sd1, 5'sd9, -5'sd1, -5'sd1, -5'sd1, -5'sd1},
    '{5'sd0, 5'sd1, 5'sd0, 5'sd0, 5'sd0, 5'sd0, 5'sd0, -5'sd1, 5'sd0},
    '{5'sd0, 5'sd0, 5'sd0, 5'sd0, 5'sd0, 5'sd0, 5'sd0, 5'sd0, 5'sd0}
  };

  // Unknown filter codes fall back to the all-zero kernel.
  function automatic weight_t kernel_weight(input logic [2:0] mode, input logic [3:0] tap);
    weight_t w;
    if (mode > FM_ZERO || tap > 4'd8) begin
      w = '0;
    end else begin
      w = KERNELS[mode][tap];
    end
    return w;
  endfunction

endpackage

`default_nettype wire

[sv/i3kf_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Used for the combined line stores; no package dependency.
`default_nettype none

module i3kf_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 4096
) (
  input  wire                      clk_i,
  input  wire                      we_i,
  input  wire [$clog2(DEPTH)-1:0]  waddr_i,
  input  wire [WIDTH-1:0]          wdata_i,
  input  wire                      re_i,
  input  wire [$clog2(DEPTH)-1:0]  raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[sv/i3kf_lane.sv]
// One filter lane: weighted 3x3 sum of one 8-bit channel, registered, then
// constant division and saturation. Depends on i3kf_pkg.
`default_nettype none

module i3kf_lane (
  input  wire        clk_i,
  input  wire [2:0]  mode_i,
  input  wire [7:0]  taps_i [9],
  output logic [7:0] result_o
);
  import i3kf_pkg::*;

  logic signed [SUM_W-1:0] sum_d, sum_q;
  logic [11:0]             mag;
  logic [24:0]             prod9;
  logic [26:0]             prod3;
  logic [11:0]             quot;

  always_comb begin
    sum_d = '0;
    for (int n = 0; n < 9; n++) begin
      sum_d = sum_d + SUM_W'(kernel_weight(mode_i, 4'(n)))
                    * SUM_W'($signed({1'b0, taps_i[n]}));
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q <= sum_d;
  end

  // Only positive sums reach the divider, so the magnitude fits 12 bits.
  assign mag   = sum_q[11:0];
  assign prod9 = 25'(mag) * 25'(RECIP9);
  assign prod3 = 27'(mag) * 27'(RECIP3);

  always_comb begin
    case (mode_i)
      FM_SMOOTH:  quot = 12'(prod9[24:RECIP_SHIFT]);
      FM_BLUR:    quot = 12'(mag[11:4]);
      FM_SHARPEN: quot = 12'(prod3[26:RECIP_SHIFT]);
      default:    quot = mag;
    endcase
  end

  always_comb begin
    if (sum_q <= 0) begin
      result_o = 8'd0;
    end else if (quot > 12'd255) begin
      result_o = 8'd255;
    end else begin
      result_o = quot[7:0];
    end
  end

endmodule

`default_nettype wire

[sv/i3kf_merge.sv]
// Merging stage: picks lane results or the unfiltered center per pixel, masks
// grey mode and queues results for the output channel. Depends on i3kf_pkg.
`default_nettype none

module i3kf_merge (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  i3kf_pkg::stage_ctl_t         ctl_i,
  input  i3kf_pkg::pixel_t             center_i,
  input  wire [7:0]                    lane_i [3],
  input  wire                          color_mode_i,
  output logic                         out_valid_o,
  input  wire                          out_ready_i,
  output i3kf_pkg::pixel_out_t         out_data_o,
  output logic [i3kf_pkg::OQ_CNT_W-1:0] fill_o
);
  import i3kf_pkg::*;

  pixel_out_t          item;
  pixel_out_t          mem_q [OQ_DEPTH];
  logic [OQ_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [OQ_CNT_W-1:0] count_q;
  logic                push, pop;

  always_comb begin
    if (ctl_i.border) begin
      item.red_out   = center_i[7:0];
      item.green_out = center_i[15:8];
      item.blue_out  = center_i[23:16];
    end else begin
      item.red_out   = lane_i[0];
      item.green_out = lane_i[1];
      item.blue_out  = lane_i[2];
    end
    if (!color_mode_i) begin
      item.green_out = 8'd0;
      item.blue_out  = 8'd0;
    end
    item.frame_last = ctl_i.last;
  end

  assign push = ctl_i.emit;
  assign pop  = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_q + OQ_CNT_W'(push) - OQ_CNT_W'(pop);
    end
  end

  assign out_valid_o = (count_q != '0);
  assign out_data_o  = mem_q[rd_ptr_q];
  assign fill_o      = count_q;

endmodule

`default_nettype wire

[sv/image_3x3_kernel_filter.sv]
// Top level of the 3x3 kernel image filter: position counters, line store RAM,
// window, three filter lanes and the merging stage. Depends on i3kf_pkg.
//
// Pixels of a frame enter in raster order, one request per clock, and the block
// keeps that rate indefinitely while the output side takes one result per clock.
// A result passes the line store read (the single RAM holds both stored rows and
// is read and written once per cycle), the window shift, the registered weighted
// sums, then the division and merge on its way into the output queue. Results
// lag the pixel stream by one row plus one pixel; flush requests after the last
// pixel drain that lag. in_ready_o drops only when the eight-entry output queue,
// counting results still in the pipeline, is full. The line stores have no
// clearing pass after reset. The user must write configuration only while the
// block is idle (not enforced); writing the width or height restarts the frame.
`default_nettype none

module image_3x3_kernel_filter #(
  parameter int unsigned MAX_WIDTH = 4096
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    in_valid_i,
  output logic                   in_ready_o,
  input  i3kf_pkg::pixel_in_t    in_data_i,
  output logic                   out_valid_o,
  input  wire                    out_ready_i,
  output i3kf_pkg::pixel_out_t   out_data_o,
  input  wire                    cfg_we_i,
  input  wire [1:0]              cfg_index_i,
  input  wire [15:0]             cfg_data_i
);
  import i3kf_pkg::*;

  localparam int unsigned CW  = $clog2(MAX_WIDTH);
  localparam int unsigned CW1 = $clog2(MAX_WIDTH + 1);

  typedef struct packed {
    logic shift;
    logic zero;
    logic we;
  } s1_ctl_t;

  // Configuration
  logic [2:0]  filter_mode_q;
  logic [12:0] image_width_q;
  logic [15:0] image_height_q;
  logic        color_mode_q;
  logic        geom_write;

  // Positions
  logic [CW-1:0] col_q, ocol_q;
  logic [15:0]   row_q, orow_q;

  logic [CW1-1:0] eff_w;
  logic [CW-1:0]  w_m1;
  logic [15:0]    eff_h, h_m1;

  logic   accept, draining, pixel_op, emit, last_sel, border, col_wrap, rd_en;
  pixel_t pix;

  // Pipeline
  s1_ctl_t    s1_q;
  stage_ctl_t s1_ctl_q, s2_ctl_q, s3_ctl_q;
  logic [CW-1:0] s1_addr_q;
  pixel_t        s1_pix_q;
  pixel_t        center_q;
  logic [47:0]   rdata;
  pixel_t        col_top, col_mid;
  pixel_t        win_q [9];

  logic [7:0]          taps [3][9];
  logic [7:0]          lane_res [3];
  logic [OQ_CNT_W-1:0] fill;
  logic [OQ_CNT_W:0]   occ;

  // ---------------------------------------------------------------- config
  assign geom_write = cfg_we_i && (cfg_index_e'(cfg_index_i) == CFG_IMAGE_WIDTH ||
                                   cfg_index_e'(cfg_index_i) == CFG_IMAGE_HEIGHT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filter_mode_q  <= FILTER_MODE_RST;
      image_width_q  <= IMAGE_WIDTH_RST;
      image_height_q <= IMAGE_HEIGHT_RST;
      color_mode_q   <= COLOR_MODE_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_e'(cfg_index_i))
        CFG_FILTER_MODE:  filter_mode_q  <= cfg_data_i[2:0];
        CFG_IMAGE_WIDTH:  image_width_q  <= cfg_data_i[12:0];
        CFG_IMAGE_HEIGHT: image_height_q <= cfg_data_i[15:0];
        CFG_COLOR_MODE:   color_mode_q   <= cfg_data_i[0];
        default:          ;
      endcase
    end
  end

  always_comb begin
    if (image_width_q < 13'd3) begin
      eff_w = CW1'(3);
    end else if (32'(image_width_q) > 32'(MAX_WIDTH)) begin
      eff_w = CW1'(MAX_WIDTH);
    end else begin
      eff_w = CW1'(image_width_q);
    end
    eff_h = (image_height_q < 16'd3) ? 16'd3 : image_height_q;
  end

  assign w_m1 = CW'(eff_w - CW1'(1));
  assign h_m1 = eff_h - 16'd1;

  // ---------------------------------------------------------------- control
  assign occ        = (OQ_CNT_W + 1)'(fill) + (OQ_CNT_W + 1)'(s1_ctl_q.emit)
                    + (OQ_CNT_W + 1)'(s2_ctl_q.emit) + (OQ_CNT_W + 1)'(s3_ctl_q.emit);
  assign in_ready_o = (occ < (OQ_CNT_W + 1)'(OQ_DEPTH));
  assign accept     = in_valid_i && in_ready_o;

  // Once all rows are in, every request drains one result, pixels included.
  assign draining = (row_q >= eff_h);
  assign pixel_op = !draining && (in_data_i.command == CMD_PIXEL);
  assign col_wrap = (col_q >= w_m1);
  assign last_sel = (orow_q == h_m1) && (ocol_q == w_m1);
  assign emit     = draining ||
                    (pixel_op && (row_q >= 16'd2 || (row_q == 16'd1 && col_q != '0)));
  assign border   = (orow_q == 16'd0) || (orow_q >= h_m1) ||
                    (ocol_q == '0) || (ocol_q == w_m1);
  assign rd_en    = accept && (pixel_op || (draining && !last_sel));

  assign pix = color_mode_q ? {in_data_i.blue_in, in_data_i.green_in, in_data_i.red_in}
                            : {16'd0, in_data_i.red_in};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      ocol_q <= '0;
      orow_q <= '0;
    end else if (geom_write) begin
      col_q  <= '0;
      row_q  <= '0;
      ocol_q <= '0;
      orow_q <= '0;
    end else if (accept) begin
      if (pixel_op) begin
        if (col_wrap) begin
          col_q <= '0;
          row_q <= row_q + 16'd1;
        end else begin
          col_q <= col_q + 1'b1;
        end
      end else if (draining && !last_sel && !col_wrap) begin
        col_q <= col_q + 1'b1;
      end
      if (emit) begin
        if (last_sel) begin
          col_q  <= '0;
          row_q  <= '0;
          ocol_q <= '0;
          orow_q <= '0;
        end else if (ocol_q == w_m1) begin
          ocol_q <= '0;
          orow_q <= orow_q + 16'd1;
        end else begin
          ocol_q <= ocol_q + 1'b1;
        end
      end
    end
  end

  // ---------------------------------------------------------------- stage 1
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q     <= '0;
      s1_ctl_q <= '0;
      s2_ctl_q <= '0;
      s3_ctl_q <= '0;
    end else begin
      s1_q.shift    <= accept && (pixel_op || draining);
      s1_q.zero     <= accept && draining && last_sel;
      s1_q.we       <= accept && pixel_op;
      s1_ctl_q.emit   <= accept && emit;
      s1_ctl_q.border <= border;
      s1_ctl_q.last   <= draining && last_sel;
      s2_ctl_q <= s1_ctl_q;
      s3_ctl_q <= s2_ctl_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_addr_q <= col_q;
      s1_pix_q  <= pixel_op ? pix : '0;
    end
  end

  // Upper row in the high half, middle row in the low half of each entry.
  i3kf_ram #(
    .WIDTH (48),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (s1_q.shift && s1_q.we),
    .waddr_i (s1_addr_q),
    .wdata_i ({rdata[23:0], s1_pix_q}),
    .re_i    (rd_en),
    .raddr_i (col_q),
    .rdata_o (rdata)
  );

  assign col_top = s1_q.zero ? '0 : rdata[47:24];
  assign col_mid = s1_q.zero ? '0 : rdata[23:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 9; i++) begin
        win_q[i] <= '0;
      end
    end else if (s1_q.shift) begin
      for (int i = 0; i < 3; i++) begin
        win_q[i*3 + 0] <= win_q[i*3 + 1];
        win_q[i*3 + 1] <= win_q[i*3 + 2];
      end
      win_q[2] <= col_top;
      win_q[5] <= col_mid;
      win_q[8] <= s1_pix_q;
    end
  end

  // ---------------------------------------------------------------- stage 2
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      for (int n = 0; n < 9; n++) begin
        taps[l][n] = win_q[n][l*8 +: 8];
      end
    end
  end

  for (genvar l = 0; l < 3; l++) begin : g_lane
    i3kf_lane u_lane (
      .clk_i    (clk_i),
      .mode_i   (filter_mode_q),
      .taps_i   (taps[l]),
      .result_o (lane_res[l])
    );
  end

  always_ff @(posedge clk_i) begin
    center_q <= win_q[4];
  end

  // ---------------------------------------------------------------- stage 3
  i3kf_merge u_merge (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (s3_ctl_q),
    .center_i     (center_q),
    .lane_i       (lane_res),
    .color_mode_i (color_mode_q),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o),
    .fill_o       (fill)
  );

`ifndef NO_ASSERTIONS
  // The queue plus results in flight never exceed its depth.
  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ <= (OQ_CNT_W + 1)'(OQ_DEPTH))
    else $error("output queue overflow");

  // A zero shift happens only for the final result of a frame.
  a_zero_is_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_q.zero |-> (s1_q.shift && s1_ctl_q.emit && s1_ctl_q.last))
    else $error("zero shift without frame end");

  // Column counters stay inside the row.
  a_col_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (col_q <= w_m1) && (ocol_q <= w_m1))
    else $error("column counter out of range");

  // After the final result of a frame the positions restart.
  a_frame_restart : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && emit && last_sel) |=> (row_q == 16'd0 && orow_q == 16'd0))
    else $error("frame did not restart");
`endif

endmodule

`default_nettype wire

[tb/image_3x3_kernel_filter_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for image_3x3_kernel_filter: streams directed and random frames
// through the filter and checks each result against a predictor kept in step with the
// accepted requests. Depends on i3kf_pkg and the filter RTL.
module image_3x3_kernel_filter_tb;
  import i3kf_pkg::*;

  localparam int unsigned LINE_DEPTH     = 4096;
  localparam int unsigned TIMEOUT_CYCLES = 1000000;
  localparam int unsigned SETTLE_CYCLES  = 24;
  localparam int unsigned RANDOM_ITEMS   = 250;
  localparam int unsigned MAX_REPORTS    = 10;
  localparam int unsigned WIDE_COLS      = 24;
  localparam int unsigned TALL_PIXELS    = 12;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  pixel_in_t   in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  pixel_out_t  out_data;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_FILTER_MODE;
  logic [15:0] cfg_data = '0;

  pixel_in_t   pending_requests [$];
  pixel_out_t  expected_pixels [$];
  pixel_out_t  expected_head;
  int unsigned queued_count = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned gap_left;
  int unsigned stall_left;
  bit          in_idle_en = 1'b1;
  bit          out_idle_en = 1'b1;
  int unsigned geo_w;
  int unsigned geo_h;

  // Predictor state: line stores, window, frame position and register copies.
  logic [23:0] pred_upper [LINE_DEPTH];
  logic [23:0] pred_middle [LINE_DEPTH];
  logic [23:0] pred_window [9];
  int unsigned pred_col;
  int unsigned pred_row;
  int unsigned pred_emitted;
  logic [2:0]  pred_mode;
  logic [12:0] pred_width;
  logic [15:0] pred_height;
  logic        pred_color;

  image_3x3_kernel_filter DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #1 clk_i = ~clk_i;

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void shift_window(input logic [23:0] top, input logic [23:0] mid,
                                       input logic [23:0] bot);
    logic [23:0] column [3];
    column[0] = top;
    column[1] = mid;
    column[2] = bot;
    for (int i = 0; i < 3; i++) begin
      pred_window[i * 3]     = pred_window[i * 3 + 1];
      pred_window[i * 3 + 1] = pred_window[i * 3 + 2];
      pred_window[i * 3 + 2] = column[i];
    end
  endfunction

  // Weighted sum of one channel over the window, divided and clamped to a byte.
  function automatic logic [7:0] filter_lane(input int unsigned sh);
    int v [9];
    int ring;
    int sum;
    int div;
    int q;
    for (int n = 0; n < 9; n++) v[n] = int'(pred_window[n][sh +: 8]);
    ring = v[0] + v[1] + v[2] + v[3] + v[5] + v[6] + v[7] + v[8];
    div = 1;
    case (pred_mode)
      FM_SMOOTH: begin
        sum = ring + v[4];
        div = 9;
      end
      FM_BLUR: begin
        sum = v[0] + v[2] + v[6] + v[8] + 2 * (v[1] + v[3] + v[5] + v[7]) + 4 * v[4];
        div = 16;
      end
      FM_SHARPEN: begin
        sum = 11 * v[4] - 2 * (v[1] + v[3] + v[5] + v[7]);
        div = 3;
      end
      FM_MEAN: sum = 9 * v[4] - ring;
      FM_EMBOSS: sum = v[1] - v[7];
      default: sum = 0;
    endcase
    if (sum <= 0) return 8'h00;
    q = sum / div;
    return q > 255 ? 8'hff : 8'(q);
  endfunction

  function automatic void predict_filtered_pixel(input pixel_in_t req);
    int unsigned w;
    int unsigned h;
    int unsigned c;
    int unsigned pos;
    int unsigned orow;
    int unsigned ocol;
    logic [23:0] pix;
    logic [23:0] ctr;
    pixel_out_t  res;
    w = pred_width < 3 ? 3 : (pred_width > LINE_DEPTH ? LINE_DEPTH : pred_width);
    h = pred_height < 3 ? 3 : pred_height;
    c = pred_col;
    if (pred_row < h) begin
      // Flushes only count once the last pixel of the frame is in.
      if (req.command == CMD_FLUSH) return;
      pix = pred_color ? {req.blue_in, req.green_in, req.red_in} : {16'h0000, req.red_in};
      shift_window(pred_upper[c], pred_middle[c], pix);
      pred_upper[c] = pred_middle[c];
      pred_middle[c] = pix;
      pos = pred_row * w + c;
      if (c + 1 >= w) begin
        pred_col = 0;
        pred_row++;
      end else begin
        pred_col = c + 1;
      end
      if (pos < w + 1) return;
    end else if (pred_emitted == h * w - 1) begin
      shift_window('0, '0, '0);
    end else begin
      // Draining: any request here, pixel or flush, pushes out one result.
      shift_window(pred_upper[c], pred_middle[c], '0);
      if (c + 1 < w) pred_col = c + 1;
    end
    orow = pred_emitted / w;
    ocol = pred_emitted % w;
    ctr = pred_window[4];
    if (orow == 0 || orow >= h - 1 || ocol == 0 || ocol == w - 1) begin
      res.red_out   = ctr[7:0];
      res.green_out = ctr[15:8];
      res.blue_out  = ctr[23:16];
    end else begin
      res.red_out   = filter_lane(0);
      res.green_out = filter_lane(8);
      res.blue_out  = filter_lane(16);
    end
    if (!pred_color) begin
      res.green_out = '0;
      res.blue_out  = '0;
    end
    res.frame_last = pred_emitted == h * w - 1;
    pred_emitted++;
    if (res.frame_last) begin
      pred_col = 0;
      pred_row = 0;
      pred_emitted = 0;
    end
    expected_pixels.push_back(res);
  endfunction

  // Request driver: pops pending requests and predicts each one as it is accepted.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_data <= '0;
      gap_left = 0;
    end else begin
      if (in_valid && in_ready) predict_filtered_pixel(in_data);
      if (!in_valid || in_ready) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_requests.size() != 0) begin
          in_data <= pending_requests.pop_front();
          in_valid <= 1'b1;
          gap_left = in_idle_en ? idle_len() : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random back-pressure.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_pixels.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("unexpected result: r=%0d g=%0d b=%0d last=%0b", out_data.red_out,
                     out_data.green_out, out_data.blue_out, out_data.frame_last);
          end
        end else begin
          expected_head = expected_pixels.pop_front();
          if (out_data.red_out !== expected_head.red_out ||
              out_data.green_out !== expected_head.green_out ||
              out_data.blue_out !== expected_head.blue_out ||
              out_data.frame_last !== expected_head.frame_last) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
              $display("mismatch: exp r=%0d g=%0d b=%0d l=%0b, got r=%0d g=%0d b=%0d l=%0b",
                       expected_head.red_out, expected_head.green_out,
                       expected_head.blue_out, expected_head.frame_last, out_data.red_out,
                       out_data.green_out, out_data.blue_out, out_data.frame_last);
            end
          end
        end
      end
      if (stall_left != 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        stall_left = out_idle_en ? idle_len() : 0;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == TIMEOUT_CYCLES) begin
      $display("image_3x3_kernel_filter_tb failed");
      $finish;
    end
  end

  task automatic write_reg(input cfg_index_e idx, input logic [15:0] value);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      CFG_FILTER_MODE: pred_mode = value[2:0];
      CFG_IMAGE_WIDTH: begin
        pred_width = value[12:0];
        pred_col = 0;
        pred_row = 0;
        pred_emitted = 0;
      end
      CFG_IMAGE_HEIGHT: begin
        pred_height = value[15:0];
        pred_col = 0;
        pred_row = 0;
        pred_emitted = 0;
      end
      default: pred_color = value[0];
    endcase
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_geometry(input int unsigned w, input int unsigned h);
    write_reg(CFG_IMAGE_WIDTH, {3'($urandom), 13'(w)});
    write_reg(CFG_IMAGE_HEIGHT, 16'(h));
    geo_w = w < 3 ? 3 : (w > LINE_DEPTH ? LINE_DEPTH : w);
    geo_h = h < 3 ? 3 : h;
  endtask

  task automatic wait_idle();
    while (pending_requests.size() != 0 || in_valid || expected_pixels.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  function automatic void queue_request(input logic cmd, input logic [7:0] r,
                                        input logic [7:0] g, input logic [7:0] b);
    pixel_in_t req;
    req.command  = cmd;
    req.red_in   = r;
    req.green_in = g;
    req.blue_in  = b;
    pending_requests.push_back(req);
    queued_count++;
  endfunction

  // Queues n_px pixels of the current geometry; a whole frame also gets its drain.
  // Noisy frames carry early flushes and pixels sent while draining.
  function automatic void queue_frame(input int unsigned n_px, input bit noisy);
    for (int unsigned i = 0; i < n_px; i++) begin
      if (noisy && $urandom_range(0, 15) == 0) begin
        queue_request(CMD_FLUSH, rand_sample(), rand_sample(), rand_sample());
      end
      queue_request(CMD_PIXEL, rand_sample(), rand_sample(), rand_sample());
    end
    if (n_px == geo_w * geo_h) begin
      for (int unsigned i = 0; i <= geo_w; i++) begin
        queue_request((noisy && $urandom_range(0, 3) == 0) ? CMD_PIXEL : CMD_FLUSH,
                      rand_sample(), rand_sample(), rand_sample());
      end
    end
  endfunction

  function automatic int unsigned pick_size(input int unsigned hi);
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, 2);
    return $urandom_range(3, hi);
  endfunction

  initial begin
    int unsigned target;
    int unsigned phase;
    bit          mid_frame;
    for (int i = 0; i < LINE_DEPTH; i++) begin
      pred_upper[i] = '0;
      pred_middle[i] = '0;
    end
    for (int i = 0; i < 9; i++) pred_window[i] = '0;
    pred_col = 0;
    pred_row = 0;
    pred_emitted = 0;
    pred_mode = FILTER_MODE_RST;
    pred_width = IMAGE_WIDTH_RST;
    pred_height = IMAGE_HEIGHT_RST;
    pred_color = COLOR_MODE_RST;
    mid_frame = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed 3x3 colour frame, widths and heights below range clamp to 3.
    // Red saturates high under the mean kernel, green goes negative and clamps to 0.
    write_reg(CFG_FILTER_MODE, {13'h1fff, FM_MEAN});
    write_reg(CFG_COLOR_MODE, 16'h0001);
    set_geometry(2, 0);
    queue_request(CMD_FLUSH, 8'hff, 8'hff, 8'hff);
    for (int i = 0; i < 9; i++) begin
      queue_request(CMD_PIXEL, i == 4 ? 8'hff : 8'h00, i == 4 ? 8'h00 : 8'hff, rand_sample());
    end
    queue_request(CMD_PIXEL, 8'h55, 8'haa, 8'h55);
    repeat (3) queue_request(CMD_FLUSH, 8'h00, 8'h00, 8'h00);
    queue_request(CMD_FLUSH, 8'haa, 8'h55, 8'haa);

    // A wide frame at full rate, then the tallest and widest frame left unfinished.
    wait_idle();
    in_idle_en = 1'b0;
    out_idle_en = 1'b0;
    write_reg(CFG_FILTER_MODE, 16'(FM_BLUR));
    set_geometry(WIDE_COLS, 3);
    queue_frame(geo_w * geo_h, 1'b0);
    wait_idle();
    set_geometry(8191, 65535);
    queue_frame(TALL_PIXELS, 1'b0);
    mid_frame = 1'b1;

    target = queued_count + RANDOM_ITEMS;
    phase = 0;
    while (queued_count < target || phase < 8) begin
      wait_idle();
      in_idle_en = $urandom_range(0, 4) != 0;
      out_idle_en = $urandom_range(0, 4) != 0;
      write_reg(CFG_FILTER_MODE, {13'($urandom), 3'(phase % 8)});
      write_reg(CFG_COLOR_MODE, {15'($urandom), 1'((phase / 2) % 2)});
      if (mid_frame || $urandom_range(0, 2) != 0) set_geometry(pick_size(6), pick_size(5));
      mid_frame = 1'b0;
      repeat ($urandom_range(1, 2)) queue_frame(geo_w * geo_h, 1'($urandom_range(0, 1)));
      if ($urandom_range(0, 3) == 0) begin
        queue_frame($urandom_range(1, geo_w * geo_h - 1), 1'b1);
        mid_frame = 1'b1;
      end
      phase++;
    end

    wait_idle();
    if (mismatch_count == 0) begin
      $display("image_3x3_kernel_filter_tb passed");
    end else begin
      $display("image_3x3_kernel_filter_tb failed");
    end
    $finish;
  end

endmodule
